FILE: rtl/lufe_pkg.sv
// Shared types, constants and saturation helpers for the LU factorization engine.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lufe_pkg;

  // Fixed widths of the request and response fields
  localparam int DATA_W        = 32;
  localparam int IDX_PORT_W    = 6;
  localparam int REQ_W         = 2;
  localparam int STAT_W        = 2;
  localparam int SIZE_W        = 7;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 3;

  // Defaults for the top-level parameters
  localparam int MATRIX_SIZE_DEF = 64;
  localparam int FRAC_BITS_DEF   = 16;
  localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RST = 7'd64;

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE  = 2'd0,
    REQ_START  = 2'd1,
    REQ_READ_L = 2'd2,
    REQ_READ_U = 2'd3
  } req_kind_t;

  // Response status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_PIVOT = 2'd1,
    ST_RANGE      = 2'd2
  } status_t;

  // Register map
  localparam logic REG_ACTIVE_SIZE = 1'b0;

  // Shared arithmetic unit command
  typedef enum logic {
    OP_DIV = 1'b0,
    OP_MUL = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_cmd_t;

  // Sequencer status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
    logic zero_pivot;
  } seq_stat_t;

  // Apply a sign to a magnitude and clamp to the signed 32-bit range
  function automatic logic [DATA_W-1:0] sat_mag(input logic [63:0] m, input logic neg);
    if (neg) begin
      if (m > 64'h0000_0000_8000_0000) return 32'h8000_0000;
      else return ~m[DATA_W-1:0] + 32'd1;
    end else if (m > 64'h0000_0000_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else begin
      return m[DATA_W-1:0];
    end
  endfunction

  // Clamp a 33-bit signed difference to 32 bits
  function automatic logic [DATA_W-1:0] sat_diff(input logic [DATA_W:0] d);
    if (d[DATA_W] != d[DATA_W-1]) return d[DATA_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else return d[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lufe_chan_if.sv
// Valid/ready channel interfaces for requests and responses of the LU engine.
// Depends on lufe_pkg for field widths.
`default_nettype none

interface lufe_req_if;
  import lufe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [IDX_PORT_W-1:0]    row_index;
  logic [IDX_PORT_W-1:0]    col_index;
  logic signed [DATA_W-1:0] element_value;

  modport source (output valid, req_type, row_index, col_index, element_value, input ready);
  modport sink   (input valid, req_type, row_index, col_index, element_value, output ready);
endinterface

interface lufe_rsp_if;
  import lufe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [STAT_W-1:0]        status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/lufe_store.sv
// Matrix storage: one write port and one registered read port.
// Depends on lufe_pkg for the data width.
`default_nettype none

module lufe_store #(
  parameter int AW = 12
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [lufe_pkg::DATA_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [AW-1:0]             raddr,
  output logic [lufe_pkg::DATA_W-1:0]    rdata
);
  import lufe_pkg::*;

  logic [DATA_W-1:0] ram [2**AW];

  // Write port
  always_ff @(posedge clk) begin
    if (we) ram[waddr] <= wdata;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) rdata <= ram[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/lufe_arith.sv
// Shared fixed-point unit: restoring divider (one quotient bit per cycle) and
// a registered 32x32 multiplier, both with saturation. Depends on lufe_pkg.
`default_nettype none

module lufe_arith #(
  parameter int FRAC_BITS = lufe_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lufe_pkg::arith_cmd_t        cmd,
  input  wire logic [lufe_pkg::DATA_W-1:0] op_a,
  input  wire logic [lufe_pkg::DATA_W-1:0] op_b,
  output logic                             done,
  output logic [lufe_pkg::DATA_W-1:0]      result
);
  import lufe_pkg::*;

  localparam int DW  = DATA_W + FRAC_BITS;
  localparam int CW  = $clog2(DW + 1);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_DIV  = 4'b0010,
    A_MUL  = 4'b0100,
    A_FIN  = 4'b1000
  } astate_t;

  astate_t           state;
  arith_op_t         op;
  logic              neg;
  logic [DATA_W-1:0] ma, mb;
  logic [DW-1:0]     dvd, quo;
  logic [DATA_W-1:0] rem;
  logic [CW-1:0]     cnt;
  logic [63:0]       prod;

  logic [DATA_W-1:0] mag_a, mag_b;
  logic [DATA_W:0]   rem_sh;
  logic              ge;
  logic [63:0]       fin_mag;

  // Operand magnitudes
  assign mag_a = op_a[DATA_W-1] ? (~op_a + 32'd1) : op_a;
  assign mag_b = op_b[DATA_W-1] ? (~op_b + 32'd1) : op_b;

  // One restoring step
  assign rem_sh = {rem, dvd[DW-1]};
  assign ge     = rem_sh >= {1'b0, mb};

  assign fin_mag = (op == OP_DIV) ? 64'(quo) : (prod >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        A_IDLE: begin
          if (cmd.start) begin
            op  <= cmd.op;
            ma  <= mag_a;
            mb  <= mag_b;
            neg <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
            dvd <= DW'(mag_a) << FRAC_BITS;
            quo <= '0;
            rem <= '0;
            cnt <= CW'(DW);
            state <= (cmd.op == OP_DIV) ? A_DIV : A_MUL;
          end
        end
        A_DIV: begin
          rem <= ge ? DATA_W'(rem_sh - {1'b0, mb}) : rem_sh[DATA_W-1:0];
          quo <= {quo[DW-2:0], ge};
          dvd <= dvd << 1;
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) state <= A_FIN;
        end
        A_MUL: begin
          prod  <= 64'(ma) * 64'(mb);
          state <= A_FIN;
        end
        A_FIN: begin
          result <= sat_mag(fin_mag, neg);
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lufe_seq.sv
// Factorization sequencer: walks pivot, row and column indices, drives the
// matrix store and the shared arithmetic unit. Depends on lufe_pkg.
`default_nettype none

module lufe_seq #(
  parameter int IDX_W = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [IDX_W-1:0]            n_m1,
  input  wire logic [lufe_pkg::DATA_W-1:0] rdata,
  input  wire logic                        ar_done,
  input  wire logic [lufe_pkg::DATA_W-1:0] ar_result,
  output lufe_pkg::arith_cmd_t             ar_cmd,
  output logic [lufe_pkg::DATA_W-1:0]      ar_a,
  output logic [lufe_pkg::DATA_W-1:0]      ar_b,
  output logic                             mem_we,
  output logic [2*IDX_W-1:0]               mem_waddr,
  output logic [lufe_pkg::DATA_W-1:0]      mem_wdata,
  output logic                             mem_re,
  output logic [2*IDX_W-1:0]               mem_raddr,
  output lufe_pkg::seq_stat_t              stat
);
  import lufe_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_PRD   = 13'b0000000000010,
    S_PWAIT = 13'b0000000000100,
    S_MRD   = 13'b0000000001000,
    S_MWAIT = 13'b0000000010000,
    S_DIV   = 13'b0000000100000,
    S_MWR   = 13'b0000001000000,
    S_URD   = 13'b0000010000000,
    S_ARD   = 13'b0000100000000,
    S_AGET  = 13'b0001000000000,
    S_MULW  = 13'b0010000000000,
    S_KWR   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } sstate_t;

  sstate_t           state;
  logic [IDX_W-1:0]  i, j, k, last;
  logic [DATA_W-1:0] piv, m, aval, pval;
  logic              zp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      zp    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            i     <= '0;
            last  <= n_m1;
            zp    <= 1'b0;
            state <= S_PRD;
          end
        end
        S_PRD: state <= S_PWAIT;
        // Pivot arrives; a zero pivot is flagged and gives zero multipliers
        S_PWAIT: begin
          piv <= rdata;
          if (rdata == '0) zp <= 1'b1;
          if (i == last) begin
            state <= S_DONE;
          end else begin
            j     <= i + IDX_W'(1);
            state <= S_MRD;
          end
        end
        S_MRD: state <= S_MWAIT;
        S_MWAIT: begin
          if (piv == '0) begin
            m     <= '0;
            state <= S_MWR;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (ar_done) begin
            m     <= ar_result;
            state <= S_MWR;
          end
        end
        // Store multiplier; a zero multiplier leaves the row unchanged
        S_MWR: begin
          if (m != '0) begin
            k     <= i + IDX_W'(1);
            state <= S_URD;
          end else if (j == last) begin
            i     <= i + IDX_W'(1);
            state <= S_PRD;
          end else begin
            j     <= j + IDX_W'(1);
            state <= S_MRD;
          end
        end
        S_URD: state <= S_ARD;
        S_ARD: state <= S_AGET;
        S_AGET: begin
          aval  <= rdata;
          state <= S_MULW;
        end
        S_MULW: begin
          if (ar_done) begin
            pval  <= ar_result;
            state <= S_KWR;
          end
        end
        // Row update written back; step column, then row, then pivot
        S_KWR: begin
          if (k != last) begin
            k     <= k + IDX_W'(1);
            state <= S_URD;
          end else if (j != last) begin
            j     <= j + IDX_W'(1);
            state <= S_MRD;
          end else begin
            i     <= i + IDX_W'(1);
            state <= S_PRD;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Memory and arithmetic drive
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = {i, i};
    mem_we    = 1'b0;
    mem_waddr = {j, i};
    mem_wdata = m;
    ar_cmd    = '{start: 1'b0, op: OP_DIV};
    ar_a      = rdata;
    ar_b      = piv;
    unique case (state)
      S_PRD: begin
        mem_re = 1'b1;
      end
      S_MRD: begin
        mem_re    = 1'b1;
        mem_raddr = {j, i};
      end
      S_MWAIT: begin
        ar_cmd = '{start: (piv != '0), op: OP_DIV};
      end
      S_MWR: begin
        mem_we = 1'b1;
      end
      S_URD: begin
        mem_re    = 1'b1;
        mem_raddr = {i, k};
      end
      S_ARD: begin
        mem_re    = 1'b1;
        mem_raddr = {j, k};
        ar_cmd    = '{start: 1'b1, op: OP_MUL};
        ar_a      = m;
        ar_b      = rdata;
      end
      S_KWR: begin
        mem_we    = 1'b1;
        mem_waddr = {j, k};
        mem_wdata = sat_diff({aval[DATA_W-1], aval} - {pval[DATA_W-1], pval});
      end
      default: begin
      end
    endcase
  end

  assign stat.busy       = (state != S_IDLE);
  assign stat.done       = (state == S_DONE);
  assign stat.zero_pivot = zp;

endmodule

`default_nettype wire

FILE: rtl/lu_factorization_engine.sv
// LU factorization engine (Doolittle, no pivoting), signed fixed point.
// Element writes and out-of-range requests answer in the cycle after
// acceptance; L/U reads pass through the registered store read and then the
// response register. A new request is taken once the previous response has
// been or is being taken. A start request runs the factorization through one
// shared divide/multiply unit (bit-serial divide) and a single store port,
// skipping the row update where a multiplier is zero. No request is taken
// during the run. Depends on lufe_pkg, lufe_chan_if, lufe_store, lufe_arith
// and lufe_seq.
`default_nettype none

module lu_factorization_engine #(
  parameter int MATRIX_SIZE = lufe_pkg::MATRIX_SIZE_DEF,
  parameter int FRAC_BITS   = lufe_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  lufe_req_if.sink                             req,
  lufe_rsp_if.source                           rsp,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lufe_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lufe_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lufe_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import lufe_pkg::*;

  localparam int IDX_W = $clog2(MATRIX_SIZE);
  localparam int AW    = 2 * IDX_W;
  localparam int NW    = $clog2(MATRIX_SIZE + 1);
  localparam int CW    = (NW > SIZE_W) ? NW : SIZE_W;

  typedef enum logic [2:0] {
    RS_ZERO = 3'b001,
    RS_ONE  = 3'b010,
    RS_MEM  = 3'b100
  } rd_sel_t;

  logic [SIZE_W-1:0] active_size;
  logic              zero_pivot_seen;
  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  logic [STAT_W-1:0] out_status;
  logic              rd_pend;
  rd_sel_t           rd_sel;

  logic [CW-1:0]     n_full;
  logic [IDX_W-1:0]  n_m1;
  logic              accept, in_range;
  logic [IDX_W-1:0]  row_i, col_i;
  req_kind_t         kind;
  logic [STAT_W-1:0] flag_status;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  arith_cmd_t        ar_cmd;
  logic [DATA_W-1:0] ar_a, ar_b, ar_result;
  logic              ar_done;

  logic              sq_we, sq_re;
  logic [AW-1:0]     sq_waddr, sq_raddr;
  logic [DATA_W-1:0] sq_wdata;
  seq_stat_t         seq_stat;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACTIVE_SIZE) ? APB_DATA_W'(active_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= ACTIVE_SIZE_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_SIZE)) begin
      active_size <= pwdata[SIZE_W-1:0];
    end
  end

  // Order in use: zero acts as one, clamped to the built size
  always_comb begin
    if (active_size == '0) n_full = CW'(1);
    else if (CW'(active_size) > CW'(MATRIX_SIZE)) n_full = CW'(MATRIX_SIZE);
    else n_full = CW'(active_size);
  end
  assign n_m1 = IDX_W'(n_full - CW'(1));

  // Request decode
  assign kind        = req_kind_t'(req.req_type);
  assign row_i       = IDX_W'(req.row_index);
  assign col_i       = IDX_W'(req.col_index);
  assign in_range    = (CW'(req.row_index) < n_full) && (CW'(req.col_index) < n_full);
  assign flag_status = zero_pivot_seen ? ST_ZERO_PIVOT : ST_OK;
  assign req.ready   = !seq_stat.busy && !rd_pend && (!out_valid || rsp.ready);
  assign accept      = req.valid && req.ready;

  // Store port: sequencer owns it during a run
  always_comb begin
    if (seq_stat.busy) begin
      mem_we    = sq_we;
      mem_waddr = sq_waddr;
      mem_wdata = sq_wdata;
      mem_re    = sq_re;
      mem_raddr = sq_raddr;
    end else begin
      mem_we    = accept && (kind == REQ_WRITE) && in_range;
      mem_waddr = {row_i, col_i};
      mem_wdata = req.element_value;
      mem_re    = accept && (kind == REQ_READ_L || kind == REQ_READ_U) && in_range;
      mem_raddr = {row_i, col_i};
    end
  end

  // Read select and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      rd_pend         <= 1'b0;
      zero_pivot_seen <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      rd_pend <= 1'b0;
      priority if (rd_pend) begin
        out_valid  <= 1'b1;
        out_status <= flag_status;
        unique case (rd_sel)
          RS_ZERO: out_value <= '0;
          RS_ONE:  out_value <= DATA_W'(1) << FRAC_BITS;
          RS_MEM:  out_value <= mem_rdata;
          default: out_value <= '0;
        endcase
      end else if (seq_stat.done) begin
        zero_pivot_seen <= seq_stat.zero_pivot;
        out_valid       <= 1'b1;
        out_value       <= '0;
        out_status      <= seq_stat.zero_pivot ? ST_ZERO_PIVOT : ST_OK;
      end else if (accept && kind != REQ_START) begin
        if (!in_range) begin
          out_valid  <= 1'b1;
          out_value  <= '0;
          out_status <= ST_RANGE;
        end else if (kind == REQ_WRITE) begin
          out_valid  <= 1'b1;
          out_value  <= '0;
          out_status <= flag_status;
        end else begin
          rd_pend <= 1'b1;
          if (kind == REQ_READ_L) begin
            if (row_i == col_i) rd_sel <= RS_ONE;
            else if (row_i > col_i) rd_sel <= RS_MEM;
            else rd_sel <= RS_ZERO;
          end else begin
            rd_sel <= (row_i <= col_i) ? RS_MEM : RS_ZERO;
          end
        end
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.status     = out_status;

  lufe_store #(.AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lufe_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
    .clk    (clk),
    .rst    (rst),
    .cmd    (ar_cmd),
    .op_a   (ar_a),
    .op_b   (ar_b),
    .done   (ar_done),
    .result (ar_result)
  );

  lufe_seq #(.IDX_W(IDX_W)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && kind == REQ_START),
    .n_m1      (n_m1),
    .rdata     (mem_rdata),
    .ar_done   (ar_done),
    .ar_result (ar_result),
    .ar_cmd    (ar_cmd),
    .ar_a      (ar_a),
    .ar_b      (ar_b),
    .mem_we    (sq_we),
    .mem_waddr (sq_waddr),
    .mem_wdata (sq_wdata),
    .mem_re    (sq_re),
    .mem_raddr (sq_raddr),
    .stat      (seq_stat)
  );

  // A pending read and the end of a run never compete for the response
  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    !(rd_pend && seq_stat.done))
    else $error("read response and run completion collide");

  // No request is taken while the sequencer owns the store
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |-> !seq_stat.busy)
    else $error("request accepted during factorization");

  // End of a run produces its response
  a_done_rsp: assert property (@(posedge clk) disable iff (rst)
    seq_stat.done |=> out_valid)
    else $error("run finished without a response");

  // A pending read produces its response
  a_rd_rsp: assert property (@(posedge clk) disable iff (rst)
    rd_pend |=> out_valid)
    else $error("read finished without a response");

endmodule

`default_nettype wire
